@@ sv/baro_pkg.sv @@
// ----------------------------------------------------------------------------
// baro_pkg: shared types and constants for barometer compensation
// Payload structs, register indexes, sequencer states and fixed scaling.
// ----------------------------------------------------------------------------
package baro_pkg;

    localparam int RAW_W     = 24;   // raw conversion width
    localparam int COEF_W    = 16;   // calibration word width
    localparam int OUT_W     = 32;   // compensated result width
    localparam int CFG_IDX_W = 3;    // register index width
    localparam int DT_W      = 26;   // temperature difference
    localparam int TEMP_W    = 20;   // first-order temperature
    localparam int T2_W      = 20;   // second-order temperature term
    localparam int CORR_W    = 40;   // offset / sensitivity corrections
    localparam int MUL_W     = 26;   // shared multiplier operand width
    localparam int PROD_W    = 2 * MUL_W;
    localparam int OFFS_W    = 42;   // pressure offset
    localparam int SENS_W    = 41;   // pressure sensitivity
    localparam int ACC_W     = 64;   // raw * sensitivity accumulator
    localparam int DIFF_W    = 44;   // scaled product minus offset

    localparam int TEMP_BASE     = 2000;
    localparam int TEMP_VLOW     = -1500;
    localparam int REF_SHIFT     = 8;
    localparam int GAIN_SHIFT    = 23;
    localparam int GAIN_RND      = (1 << GAIN_SHIFT) - 1;
    localparam int T2_SHIFT      = 31;
    localparam int OFF_SHIFT     = 16;
    localparam int SENS_SHIFT    = 15;
    localparam int OFF_TC_SHIFT  = 7;
    localparam int SENS_TC_SHIFT = 8;
    localparam int SPLIT         = 20;  // sensitivity split for the wide product
    localparam int P_SHIFT1      = 21;
    localparam int P_SHIFT2      = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS      = 3'd0,
        CFG_OFF       = 3'd1,
        CFG_SENS_TC   = 3'd2,
        CFG_OFF_TC    = 3'd3,
        CFG_REF_TEMP  = 3'd4,
        CFG_TEMP_GAIN = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        KIND_TEMP = 1'b0,
        KIND_PRES = 1'b1
    } kind_t;

    typedef struct packed {
        logic              func;
        logic [RAW_W-1:0]  raw_sample;
    } baro_in_t;

    typedef struct packed {
        logic                     value_kind;
        logic signed [OUT_W-1:0]  compensated_value;
    } baro_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_DELTA,
        ST_T_MGAIN,
        ST_T_MSQ,
        ST_T_MTT,
        ST_T_MUU,
        ST_T_DONE,
        ST_P_MOFF,
        ST_P_MSENS,
        ST_P_SENS,
        ST_P_MHI,
        ST_P_MLO,
        ST_P_ACC,
        ST_P_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DT_GAIN,
        OP_DT_DT,
        OP_T_T,
        OP_U_U,
        OP_OFFTC_DT,
        OP_SENSTC_DT,
        OP_HI_RAW,
        OP_LO_RAW
    } op_sel_t;

endpackage

@@ sv/barometer_compensation.sv @@
// ----------------------------------------------------------------------------
// barometer_compensation: second-order barometer compensation
// Turns raw temperature and pressure conversions into calibrated values.
// ----------------------------------------------------------------------------
// Feed raw 24-bit conversions on s_data, tagged by func as temperature (0) or
// pressure (1); each beat gives exactly one result beat on m_data, in order.
// A temperature beat returns temperature in 0.01 degC and latches the
// temperature difference plus the second-order offset and sensitivity
// corrections, which every following pressure beat uses (all zero after
// reset). Pressure comes back in 0.01 mbar. Results are 32-bit two's
// complement and wrap on overflow. Load the six calibration words through
// cfg_wr_en / cfg_index / cfg_wdata while the block is idle; indexes 6 and 7
// are ignored. Datapath: one 26x26 signed multiplier, registered, is shared by
// every product under a small sequencer, and one beat is handled at a time. Each
// beat holds s_ready low from acceptance until its result is loaded, a pressure
// beat through more steps than a temperature beat (the wide raw*sensitivity
// product takes two passes through the multiplier), and longer while the full
// result register waits on m_ready. The result register lets a new beat be
// accepted while the previous result is still pending.
module barometer_compensation
    import baro_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input samples
    input  logic                  s_valid,
    output logic                  s_ready,
    input  baro_in_t              s_data,
    // compensated results
    output logic                  m_valid,
    input  logic                  m_ready,
    output baro_out_t             m_data,
    // calibration registers
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COEF_W-1:0]     cfg_wdata
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                      state_reg,     state_next;

    logic [COEF_W-1:0]           sens_coef_reg,      sens_coef_next;
    logic [COEF_W-1:0]           off_coef_reg,       off_coef_next;
    logic [COEF_W-1:0]           sens_tc_coef_reg,   sens_tc_coef_next;
    logic [COEF_W-1:0]           off_tc_coef_reg,    off_tc_coef_next;
    logic [COEF_W-1:0]           ref_temp_coef_reg,  ref_temp_coef_next;
    logic [COEF_W-1:0]           temp_gain_coef_reg, temp_gain_coef_next;

    // state kept between beats
    logic signed [DT_W-1:0]      temp_delta_reg, temp_delta_next;
    logic [CORR_W-1:0]           off_corr_reg,   off_corr_next;
    logic [CORR_W-1:0]           sens_corr_reg,  sens_corr_next;

    // working registers for the beat in flight
    logic                        kind_reg,  kind_next;
    logic [RAW_W-1:0]            raw_reg,   raw_next;
    logic signed [PROD_W-1:0]    prod_reg,  prod_next;
    logic signed [TEMP_W-1:0]    temp_reg,  temp_next;
    logic [T2_W-1:0]             t2_reg,    t2_next;
    logic [CORR_W-1:0]           sq5_reg,   sq5_next;
    logic [OFFS_W-1:0]           off_reg,   off_next;
    logic [SENS_W-1:0]           sens_reg,  sens_next;
    logic signed [ACC_W-1:0]     acc_reg,   acc_next;

    // result register
    logic                        m_valid_reg, m_valid_next;
    baro_out_t                   m_data_reg,  m_data_next;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    op_sel_t                     mul_op;
    logic                        in_accept;
    logic                        out_load;
    logic                        out_free;

    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_data.func == KIND_TEMP) begin
                        state_next = ST_T_DELTA;
                    end else begin
                        state_next = ST_P_MOFF;
                    end
                end
            end
            ST_T_DELTA: state_next = ST_T_MGAIN;
            ST_T_MGAIN: state_next = ST_T_MSQ;
            ST_T_MSQ:   state_next = ST_T_MTT;
            ST_T_MTT:   state_next = ST_T_MUU;
            ST_T_MUU:   state_next = ST_T_DONE;
            ST_T_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_P_MOFF:  state_next = ST_P_MSENS;
            ST_P_MSENS: state_next = ST_P_SENS;
            ST_P_SENS:  state_next = ST_P_MHI;
            ST_P_MHI:   state_next = ST_P_MLO;
            ST_P_MLO:   state_next = ST_P_ACC;
            ST_P_ACC:   state_next = ST_P_DONE;
            ST_P_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: multiplier operand select, ready, result load
    always_comb begin
        mul_op   = OP_NONE;
        s_ready  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:    s_ready  = 1'b1;
            ST_T_MGAIN: mul_op   = OP_DT_GAIN;
            ST_T_MSQ:   mul_op   = OP_DT_DT;
            ST_T_MTT:   mul_op   = OP_T_T;
            ST_T_MUU:   mul_op   = OP_U_U;
            ST_T_DONE:  out_load = out_free;
            ST_P_MOFF:  mul_op   = OP_OFFTC_DT;
            ST_P_MSENS: mul_op   = OP_SENSTC_DT;
            ST_P_MHI:   mul_op   = OP_HI_RAW;
            ST_P_MLO:   mul_op   = OP_LO_RAW;
            ST_P_DONE:  out_load = out_free;
            default:    mul_op   = OP_NONE;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [TEMP_W-1:0]  t_val;   // TEMP - 2000
    logic signed [TEMP_W-1:0]  u_val;   // TEMP + 1500
    logic signed [MUL_W-1:0]   raw_op;

    assign t_val  = temp_reg - TEMP_W'(TEMP_BASE);
    assign u_val  = temp_reg - TEMP_W'(TEMP_VLOW);
    assign raw_op = {{(MUL_W-RAW_W){1'b0}}, raw_reg};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (mul_op)
            OP_DT_GAIN: begin
                mul_a = temp_delta_reg;
                mul_b = {{(MUL_W-COEF_W){1'b0}}, temp_gain_coef_reg};
            end
            OP_DT_DT: begin
                mul_a = temp_delta_reg;
                mul_b = temp_delta_reg;
            end
            OP_T_T: begin
                mul_a = {{(MUL_W-TEMP_W){t_val[TEMP_W-1]}}, t_val};
                mul_b = {{(MUL_W-TEMP_W){t_val[TEMP_W-1]}}, t_val};
            end
            OP_U_U: begin
                mul_a = {{(MUL_W-TEMP_W){u_val[TEMP_W-1]}}, u_val};
                mul_b = {{(MUL_W-TEMP_W){u_val[TEMP_W-1]}}, u_val};
            end
            OP_OFFTC_DT: begin
                mul_a = {{(MUL_W-COEF_W){1'b0}}, off_tc_coef_reg};
                mul_b = temp_delta_reg;
            end
            OP_SENSTC_DT: begin
                mul_a = {{(MUL_W-COEF_W){1'b0}}, sens_tc_coef_reg};
                mul_b = temp_delta_reg;
            end
            OP_HI_RAW: begin
                // signed upper part of the sensitivity
                mul_a = {{(MUL_W-(SENS_W-SPLIT)){sens_reg[SENS_W-1]}},
                         sens_reg[SENS_W-1:SPLIT]};
                mul_b = raw_op;
            end
            OP_LO_RAW: begin
                mul_a = {{(MUL_W-SPLIT){1'b0}}, sens_reg[SPLIT-1:0]};
                mul_b = raw_op;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product only moves when an operand pair is issued
    always_comb begin
        prod_next = prod_reg;
        if (mul_op != OP_NONE) begin
            prod_next = mul_a * mul_b;
        end
    end

    // ------------------------------------------------------------------
    // Datapath terms
    // ------------------------------------------------------------------
    logic signed [DT_W-1:0]    dt_calc;
    logic signed [PROD_W-1:0]  gain_round;
    logic signed [PROD_W-1:0]  gain_quot;
    logic signed [PROD_W-1:0]  prod_sh_off;
    logic signed [PROD_W-1:0]  prod_sh_sens;
    logic signed [ACC_W-1:0]   prod_ext;
    logic [CORR_W-1:0]         prod_lo;
    logic                      temp_low;
    logic                      temp_vlow;
    logic [CORR_W-1:0]         off2;
    logic [CORR_W-1:0]         sens2;
    logic [OUT_W-1:0]          temp_out;
    logic signed [ACC_W-1:0]   acc_sh;
    logic [DIFF_W-1:0]         p_diff;
    logic [OUT_W-1:0]          pres_out;

    // dT = raw - ref * 2^8
    assign dt_calc = $signed({{(DT_W-RAW_W){1'b0}}, raw_reg})
                   - $signed({{(DT_W-COEF_W-REF_SHIFT){1'b0}}, ref_temp_coef_reg,
                              {REF_SHIFT{1'b0}}});

    // dT * gain / 2^23, truncating toward zero
    assign gain_round = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'(GAIN_RND) : PROD_W'(0));
    assign gain_quot  = gain_round >>> GAIN_SHIFT;

    assign prod_sh_off  = prod_reg >>> OFF_TC_SHIFT;
    assign prod_sh_sens = prod_reg >>> SENS_TC_SHIFT;
    assign prod_ext     = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign prod_lo      = prod_reg[CORR_W-1:0];   // squares are non-negative

    assign temp_low  = temp_reg < TEMP_W'(TEMP_BASE);
    assign temp_vlow = temp_reg < TEMP_W'(TEMP_VLOW);

    // prod_lo holds u*u in the last temperature step; very-low implies low
    assign off2  = (temp_low  ? (sq5_reg >> 1) : '0)
                 + (temp_vlow ? ((prod_lo << 3) - prod_lo) : '0);
    assign sens2 = (temp_low  ? (sq5_reg >> 2) : '0)
                 + (temp_vlow ? (((prod_lo << 3) + (prod_lo << 1) + prod_lo) >> 1) : '0);

    assign temp_out = {{(OUT_W-TEMP_W){temp_reg[TEMP_W-1]}}, temp_reg}
                    - {{(OUT_W-T2_W){1'b0}}, t2_reg};

    // P = ((raw*SENS >> 21) - OFF) >> 15
    assign acc_sh   = acc_reg >>> P_SHIFT1;
    assign p_diff   = acc_sh[DIFF_W-1:0]
                    - {{(DIFF_W-OFFS_W){off_reg[OFFS_W-1]}}, off_reg};
    assign pres_out = {{(OUT_W-(DIFF_W-P_SHIFT2)){p_diff[DIFF_W-1]}},
                       p_diff[DIFF_W-1:P_SHIFT2]};

    always_comb begin
        kind_next       = kind_reg;
        raw_next        = raw_reg;
        temp_delta_next = temp_delta_reg;
        off_corr_next   = off_corr_reg;
        sens_corr_next  = sens_corr_reg;
        temp_next       = temp_reg;
        t2_next         = t2_reg;
        sq5_next        = sq5_reg;
        off_next        = off_reg;
        sens_next       = sens_reg;
        acc_next        = acc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    kind_next = s_data.func;
                    raw_next  = s_data.raw_sample;
                end
            end
            ST_T_DELTA: temp_delta_next = dt_calc;
            ST_T_MSQ:   temp_next = gain_quot[TEMP_W-1:0] + TEMP_W'(TEMP_BASE);
            // T2 applies only below 20.00 degC
            ST_T_MTT:   t2_next   = temp_low ? prod_reg[T2_SHIFT+T2_W-1:T2_SHIFT] : '0;
            ST_T_MUU:   sq5_next  = (prod_lo << 2) + prod_lo;
            ST_T_DONE: begin
                if (out_load) begin
                    off_corr_next  = off2;
                    sens_corr_next = sens2;
                end
            end
            ST_P_MSENS: begin
                off_next = {{(OFFS_W-COEF_W-OFF_SHIFT){1'b0}}, off_coef_reg,
                            {OFF_SHIFT{1'b0}}}
                         + prod_sh_off[OFFS_W-1:0]
                         - {{(OFFS_W-CORR_W){off_corr_reg[CORR_W-1]}}, off_corr_reg};
            end
            ST_P_SENS: begin
                sens_next = {{(SENS_W-COEF_W-SENS_SHIFT){1'b0}}, sens_coef_reg,
                             {SENS_SHIFT{1'b0}}}
                          + prod_sh_sens[SENS_W-1:0]
                          - {{(SENS_W-CORR_W){sens_corr_reg[CORR_W-1]}}, sens_corr_reg};
            end
            ST_P_MLO:   acc_next = prod_ext <<< SPLIT;
            ST_P_ACC:   acc_next = acc_reg + prod_ext;
            default:    acc_next = acc_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next                 = 1'b1;
            m_data_next.value_kind       = kind_reg;
            m_data_next.compensated_value = (state_reg == ST_T_DONE) ? temp_out : pres_out;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    always_comb begin
        sens_coef_next      = sens_coef_reg;
        off_coef_next       = off_coef_reg;
        sens_tc_coef_next   = sens_tc_coef_reg;
        off_tc_coef_next    = off_tc_coef_reg;
        ref_temp_coef_next  = ref_temp_coef_reg;
        temp_gain_coef_next = temp_gain_coef_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SENS:      sens_coef_next      = cfg_wdata;
                CFG_OFF:       off_coef_next       = cfg_wdata;
                CFG_SENS_TC:   sens_tc_coef_next   = cfg_wdata;
                CFG_OFF_TC:    off_tc_coef_next    = cfg_wdata;
                CFG_REF_TEMP:  ref_temp_coef_next  = cfg_wdata;
                CFG_TEMP_GAIN: temp_gain_coef_next = cfg_wdata;
                default:       sens_coef_next      = sens_coef_reg;  // unmapped index
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flops
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            m_valid_reg        <= 1'b0;
            sens_coef_reg      <= '0;
            off_coef_reg       <= '0;
            sens_tc_coef_reg   <= '0;
            off_tc_coef_reg    <= '0;
            ref_temp_coef_reg  <= '0;
            temp_gain_coef_reg <= '0;
            temp_delta_reg     <= '0;
            off_corr_reg       <= '0;
            sens_corr_reg      <= '0;
        end else begin
            state_reg          <= state_next;
            m_valid_reg        <= m_valid_next;
            sens_coef_reg      <= sens_coef_next;
            off_coef_reg       <= off_coef_next;
            sens_tc_coef_reg   <= sens_tc_coef_next;
            off_tc_coef_reg    <= off_tc_coef_next;
            ref_temp_coef_reg  <= ref_temp_coef_next;
            temp_gain_coef_reg <= temp_gain_coef_next;
            temp_delta_reg     <= temp_delta_next;
            off_corr_reg       <= off_corr_next;
            sens_corr_reg      <= sens_corr_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        raw_reg    <= raw_next;
        prod_reg   <= prod_next;
        temp_reg   <= temp_next;
        t2_reg     <= t2_next;
        sq5_reg    <= sq5_next;
        off_reg    <= off_next;
        sens_reg   <= sens_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

endmodule

@@ sv/baro_checker.sv @@
// ----------------------------------------------------------------------------
// baro_assertions: port-level checks for barometer_compensation
// Watches handshake and sequencing behavior on the top-level ports.
// ----------------------------------------------------------------------------
module baro_assertions
    import baro_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       m_valid,
    input  logic       m_ready,
    input  baro_out_t  m_data
);

    // reset leaves the block empty and ready
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("not idle after reset");

    // one beat at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready again right after accept");

    // no result can appear in the cycle after an accept
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid)
        else $error("result appeared without compute time");

    // an idle block stays idle without input
    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready && !s_valid) |=> s_ready)
        else $error("left idle without an input beat");

    // stalled result beat holds
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result beat changed");

endmodule

bind barometer_compensation baro_assertions u_baro_assertions (.*);

@@ verif/baro_checker.sv @@
// ----------------------------------------------------------------------------
// baro_checker: result checker for barometer_compensation
// Watches the sample, result and calibration ports. It keeps its own copy of
// the calibration words and of the latched temperature state, works out the
// compensated value of every accepted sample, and compares result beats in
// order.
// ----------------------------------------------------------------------------
module baro_checker
    import baro_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  baro_in_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  baro_out_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COEF_W-1:0]     cfg_wdata,
    output int unsigned           results_checked,
    output int unsigned           fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CAL = 6;

    logic [COEF_W-1:0] cal_word [NUM_CAL];
    longint            kept_delta;
    longint            kept_offset_corr;
    longint            kept_sens_corr;
    baro_out_t         expected_values [$];

    // Compensated value of one sample. A temperature sample also refreshes the
    // latched difference and second-order corrections.
    function automatic baro_out_t compensate_sample(input baro_in_t item);
        longint    raw;
        longint    dt;
        longint    temp;
        longint    t2;
        longint    off2;
        longint    sens2;
        longint    tt;
        longint    uu;
        longint    offs;
        longint    sens;
        longint    value;
        baro_out_t res;
        raw = longint'(item.raw_sample);
        res.value_kind = item.func;
        if (kind_t'(item.func) == KIND_TEMP) begin
            dt    = raw - (longint'(cal_word[CFG_REF_TEMP]) <<< REF_SHIFT);
            // signed divide truncates toward zero, not a floor shift
            temp  = TEMP_BASE + (dt * longint'(cal_word[CFG_TEMP_GAIN]))
                    / (longint'(1) <<< GAIN_SHIFT);
            t2    = 0;
            off2  = 0;
            sens2 = 0;
            if (temp < TEMP_BASE) begin
                tt    = (temp - TEMP_BASE) * (temp - TEMP_BASE);
                t2    = (dt * dt) >>> T2_SHIFT;
                off2  = (5 * tt) / 2;
                sens2 = (5 * tt) / 4;
            end
            if (temp < TEMP_VLOW) begin
                uu    = (temp - TEMP_VLOW) * (temp - TEMP_VLOW);
                off2  = off2 + 7 * uu;
                sens2 = sens2 + (11 * uu) / 2;
            end
            kept_delta       = dt;
            kept_offset_corr = off2;
            kept_sens_corr   = sens2;
            value = temp - t2;
        end else begin
            offs  = (longint'(cal_word[CFG_OFF]) <<< OFF_SHIFT)
                  + ((longint'(cal_word[CFG_OFF_TC]) * kept_delta) >>> OFF_TC_SHIFT)
                  - kept_offset_corr;
            sens  = (longint'(cal_word[CFG_SENS]) <<< SENS_SHIFT)
                  + ((longint'(cal_word[CFG_SENS_TC]) * kept_delta) >>> SENS_TC_SHIFT)
                  - kept_sens_corr;
            value = (((sens * raw) >>> P_SHIFT1) - offs) >>> P_SHIFT2;
        end
        res.compensated_value = value[OUT_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        baro_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_CAL; i++) cal_word[i] = '0;
            kept_delta       = 0;
            kept_offset_corr = 0;
            kept_sens_corr   = 0;
            expected_values.delete();
            results_checked <= 0;
            fail_count = 0;
        end else begin
            if (cfg_wr_en && cfg_index <= CFG_TEMP_GAIN) begin
                cal_word[cfg_index] = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                results_checked <= results_checked + 1;
                if (expected_values.size() == 0) begin
                    $display("%0t: result beat with nothing expected: got kind %0d value %0d",
                             $time, m_data.value_kind, m_data.compensated_value);
                    fail_count++;
                end else begin
                    want = expected_values.pop_front();
                    if (m_data.value_kind !== want.value_kind) begin
                        $display("%0t: value_kind mismatch: expected %0d, got %0d",
                                 $time, want.value_kind, m_data.value_kind);
                        fail_count++;
                    end
                    if (m_data.compensated_value !== want.compensated_value) begin
                        $display("%0t: compensated_value mismatch: expected %0d, got %0d",
                                 $time, want.compensated_value, m_data.compensated_value);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_values.push_back(compensate_sample(s_data));
            end
        end
    end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for barometer_compensation
// Drives raw temperature and pressure beats with random gaps, stalls the
// result channel at random and loads several calibration sets between
// bursts. A directed opening hits the reset state, the field extremes and
// the edges of the low and very-low temperature branches; random bursts of
// one temperature beat and then pressure beats, or single beats of random kind,
// fill the rest. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import baro_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 400_000;
    localparam int          NUM_CAL          = 6;
    localparam int          NUM_PHASES       = 4;
    localparam int          RANDOM_PER_PHASE = 130;
    localparam int          SETTLE_CYCLES    = 20;
    localparam logic [RAW_W-1:0]     RAW_TOP      = '1;
    // indexes past the last calibration word; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    baro_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    baro_out_t             m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [COEF_W-1:0]     cfg_wdata;

    int unsigned results_checked;
    int unsigned fail_count;
    int unsigned beats_sent     = 0;
    int unsigned cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    barometer_compensation dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    baro_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .results_checked (results_checked),
        .fail_count      (fail_count)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side: ready redrawn every cycle, so stalls land on any phase of
    // the sequencer. A zero stall rate keeps ready high throughout.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // One sample beat. Optional idle cycles go first; valid is left high after
    // the handshake so back-to-back beats never drop and re-raise it in the
    // same step. Acceptance is judged on the values seen at the edge.
    task automatic send_sample(input kind_t kind, input logic [RAW_W-1:0] raw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{func: kind, raw_sample: raw};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    // Close the burst and hold until every result beat has been checked.
    // Each sample gives exactly one result, so the block is idle afterwards.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_checked != beats_sent);
    endtask

    // Writes all six words back to back, then one write to a spare index,
    // which must not disturb anything.
    task automatic load_calibration(input logic [COEF_W-1:0] words [NUM_CAL]);
        for (int i = 0; i < NUM_CAL; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_wdata <= words[i];
            @(posedge aclk);
        end
        cfg_index <= $urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO;
        cfg_wdata <= COEF_W'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Raw conversion: the rails, anywhere, or around the reference point
    // (ref word * 256) at a random spread so that the difference lands in
    // every temperature branch.
    function automatic logic [RAW_W-1:0] random_raw(input logic [COEF_W-1:0] ref_word);
        longint spread;
        longint pick;
        case ($urandom_range(3))
            0: pick = $urandom_range(1) ? longint'(RAW_TOP) : 0;
            1, 2: begin
                spread = longint'(1) <<< $urandom_range(2, 23);
                pick   = (longint'(ref_word) <<< REF_SHIFT)
                       + longint'($urandom_range(0, 32'(2 * spread))) - spread;
            end
            default: pick = longint'($urandom_range(0, 32'(RAW_TOP)));
        endcase
        if (pick < 0) pick = 0;
        if (pick > longint'(RAW_TOP)) pick = longint'(RAW_TOP);
        return pick[RAW_W-1:0];
    endfunction

    initial begin
        logic [COEF_W-1:0] words [NUM_CAL];
        int                phase_items;
        int                burst_len;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed: reset state, calibration all zero ---
        // pressure before any temperature runs on the all-zero latched state
        send_sample(KIND_PRES, RAW_TOP);
        send_sample(KIND_TEMP, 24'd8569150);
        send_sample(KIND_PRES, 24'd6465444);
        wait_drained();

        // --- directed: a typical factory calibration ---
        // ref word 33464 puts the reference point at 8566784; gain 28312
        words = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
        load_calibration(words);
        send_sample(KIND_TEMP, 24'd8569150);     // room temperature, no correction
        send_sample(KIND_PRES, 24'd6465444);
        send_sample(KIND_TEMP, '0);              // deep cold, very-low branch
        send_sample(KIND_PRES, '0);
        send_sample(KIND_PRES, RAW_TOP);
        send_sample(KIND_TEMP, RAW_TOP);         // hot, raw at the top rail
        send_sample(KIND_PRES, RAW_TOP);
        send_sample(KIND_TEMP, 24'd8566784);     // zero difference: exactly 20.00
        send_sample(KIND_TEMP, 24'd8566488);     // quotient just above -1 truncates to 0
        send_sample(KIND_TEMP, 24'd8566487);     // 19.99: low branch starts here
        send_sample(KIND_PRES, 24'd6465444);
        send_sample(KIND_TEMP, 24'd7529763);     // -15.00: still outside very-low
        send_sample(KIND_PRES, 24'd6465444);
        send_sample(KIND_TEMP, 24'd7529467);     // -15.01: very-low branch
        send_sample(KIND_PRES, 24'd6465444);
        wait_drained();

        // --- directed: every calibration bit set ---
        foreach (words[i]) words[i] = '1;
        load_calibration(words);
        send_sample(KIND_TEMP, '0);
        send_sample(KIND_PRES, RAW_TOP);
        send_sample(KIND_TEMP, RAW_TOP);
        send_sample(KIND_PRES, '0);
        wait_drained();

        // --- random: one calibration set and one idling pattern per phase ---
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 65; end
                default: begin send_idle_pct = 34; recv_stall_pct <= 34; end
            endcase
            foreach (words[i]) begin
                case ($urandom_range(7))
                    0: words[i] = '0;
                    1: words[i] = '1;
                    default: words[i] = COEF_W'($urandom);
                endcase
            end
            load_calibration(words);

            // Mostly a temperature beat followed by a few pressure beats, the
            // way the sensor is read; the rest is beats of random kind.
            phase_items = 0;
            while (phase_items < RANDOM_PER_PHASE) begin
                if ($urandom_range(9) < 8) begin
                    burst_len = $urandom_range(1, 4);
                    send_sample(KIND_TEMP, random_raw(words[CFG_REF_TEMP]));
                    repeat (burst_len) send_sample(KIND_PRES, random_raw(words[CFG_REF_TEMP]));
                    phase_items += burst_len + 1;
                end else begin
                    send_sample(kind_t'($urandom_range(1)), random_raw(words[CFG_REF_TEMP]));
                    phase_items++;
                end
            end
            wait_drained();
        end

        // let any stray result beat show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/baro_pkg.sv
sv/barometer_compensation.sv
sv/baro_checker.sv
verif/baro_checker.sv
verif/tb_top.sv
